@@ design/uartrx_pkg.sv @@
// Package for the UART register block with receive FIFO.
// Holds item structs, command and register offset codes, and FIFO interface types.
// No dependencies.
package uartrx_pkg;

  localparam int unsigned FifoDepthDef = 16;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;

  localparam logic [7:0] OFF_DATA   = 8'h00;
  localparam logic [7:0] OFF_STATUS = 8'h04;
  localparam logic [7:0] OFF_IE     = 8'h08;
  localparam logic [7:0] OFF_IS     = 8'h0C;
  localparam logic [7:0] OFF_LEVEL  = 8'h10;
  localparam logic [7:0] OFF_CTRL   = 8'h14;
  localparam logic [7:0] OFF_CAP    = 8'h18;

  localparam logic [15:0] CAP_VERSION = 16'h0001;

  typedef logic [4:0] cnt_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  bus_offset;
    logic [3:0]  access_bytes;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bus_error;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_accepted;
    logic        irq;
  } out_item_t;

  // FIFO status toward the register decode
  typedef struct packed {
    cnt_t       count;
    logic       full;
    logic [7:0] rd_byte;
  } fifo_stat_t;

  // Push/pop request toward the FIFO
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_byte;
  } fifo_req_t;

endpackage

@@ design/uartrx_fifo.sv @@
// Receive FIFO: flop storage, head pointer and fill count.
// Depends on uartrx_pkg.
module uartrx_fifo #(
  parameter int unsigned FIFO_DEPTH = uartrx_pkg::FifoDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  uartrx_pkg::fifo_req_t  req_i,
  output uartrx_pkg::fifo_stat_t stat_o
);

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  logic [7:0]      store_q [FIFO_DEPTH];
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW:0]   tail_sum;
  logic [CntW:0]   tail_wrap;
  logic [PtrW-1:0] tail_idx;
  logic            full;

  assign full      = (count_q == CntW'(FIFO_DEPTH));
  assign tail_sum  = (CntW+1)'(head_q) + (CntW+1)'(count_q);
  assign tail_wrap = (tail_sum >= (CntW+1)'(FIFO_DEPTH)) ?
                     (tail_sum - (CntW+1)'(FIFO_DEPTH)) : tail_sum;
  assign tail_idx  = tail_wrap[PtrW-1:0];

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (req_i.pop && (count_q != '0)) begin
      head_d  = (head_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : head_q + PtrW'(1);
      count_d = count_q - CntW'(1);
    end else if (req_i.push && !full) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push && !req_i.pop && !full) begin
      store_q[tail_idx] <= req_i.push_byte;
    end
  end

  assign stat_o.count   = uartrx_pkg::cnt_t'(count_q);
  assign stat_o.full    = full;
  assign stat_o.rd_byte = store_q[head_q];

endmodule

@@ design/uartrx_ctrl.sv @@
// Register decode, interrupt enable and loopback registers, result formation.
// Depends on uartrx_pkg.
module uartrx_ctrl #(
  parameter int unsigned FIFO_DEPTH = uartrx_pkg::FifoDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  uartrx_pkg::in_item_t   item_i,
  input  uartrx_pkg::fifo_stat_t stat_i,
  output uartrx_pkg::fifo_req_t  req_o,
  output uartrx_pkg::out_item_t  res_o
);

  logic [1:0]  ie_q, ie_d;
  logic        loop_q, loop_d;
  logic [31:0] mask;
  logic [31:0] wval;
  logic [31:0] rval;
  logic [7:0]  dep8;
  logic        rx_avail;
  logic        bad_off;
  logic        push, pop;
  logic [7:0]  push_byte;
  uartrx_pkg::cnt_t cnt_next;

  assign dep8     = 8'(FIFO_DEPTH);
  assign rx_avail = (stat_i.count != '0);
  assign bad_off  = (item_i.bus_offset > uartrx_pkg::OFF_CAP);
  assign wval     = item_i.write_data & mask;

  always_comb begin
    case (item_i.access_bytes)
      4'd0:    mask = 32'h0000_0000;
      4'd1:    mask = 32'h0000_00FF;
      4'd2:    mask = 32'h0000_FFFF;
      4'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  always_comb begin
    unique case (item_i.bus_offset)
      uartrx_pkg::OFF_DATA:   rval = rx_avail ? {24'd0, stat_i.rd_byte} : 32'd0;
      uartrx_pkg::OFF_STATUS: rval = {28'd0, stat_i.full, rx_avail, 1'b0,
                                      loop_q & stat_i.full};
      uartrx_pkg::OFF_IE:     rval = {30'd0, ie_q};
      uartrx_pkg::OFF_IS:     rval = {30'd0, 1'b1, rx_avail};
      uartrx_pkg::OFF_LEVEL:  rval = {27'd0, stat_i.count};
      uartrx_pkg::OFF_CTRL:   rval = {31'd0, loop_q};
      uartrx_pkg::OFF_CAP:    rval = {uartrx_pkg::CAP_VERSION, dep8, dep8};
      default:                rval = 32'd0;
    endcase
  end

  always_comb begin
    res_o      = '0;
    ie_d       = ie_q;
    loop_d     = loop_q;
    push       = 1'b0;
    pop        = 1'b0;
    push_byte  = item_i.rx_byte;
    unique case (item_i.cmd)
      uartrx_pkg::CMD_READ: begin
        if (bad_off) begin
          res_o.bus_error = 1'b1;
        end else begin
          res_o.read_data = rval & mask;
          pop = (item_i.bus_offset == uartrx_pkg::OFF_DATA) && rx_avail;
        end
      end
      uartrx_pkg::CMD_WRITE: begin
        if (bad_off) begin
          res_o.bus_error = 1'b1;
        end else if (item_i.bus_offset == uartrx_pkg::OFF_DATA) begin
          res_o.tx_valid = 1'b1;
          res_o.tx_byte  = wval[7:0];
          push_byte      = wval[7:0];
          push           = loop_q && !stat_i.full;
        end else if (item_i.bus_offset == uartrx_pkg::OFF_IE) begin
          ie_d = wval[1:0];
        end else if (item_i.bus_offset == uartrx_pkg::OFF_CTRL) begin
          loop_d = wval[0];
        end
      end
      uartrx_pkg::CMD_RX: begin
        push              = !stat_i.full;
        res_o.rx_accepted = !stat_i.full;
      end
      default: ;
    endcase
    cnt_next  = stat_i.count + uartrx_pkg::cnt_t'(push) - uartrx_pkg::cnt_t'(pop);
    res_o.irq = ie_d[0] && (cnt_next != '0);
  end

  assign req_o.push      = fire_i & push;
  assign req_o.pop       = fire_i & pop;
  assign req_o.push_byte = push_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ie_q   <= '0;
      loop_q <= 1'b0;
    end else if (fire_i) begin
      ie_q   <= ie_d;
      loop_q <= loop_d;
    end
  end

endmodule

@@ design/uart_register_block_rx_fifo.sv @@
// Top level of the UART register block with receive FIFO.
// Depends on uartrx_pkg, uartrx_fifo and uartrx_ctrl.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one item per
//   bus read, bus write or byte arriving from the line. Output channel
//   (out_valid_o / out_stall_i / out_item_o) returns exactly one result item
//   per input item, in order.
//   An item is taken into an input register, decoded and applied to the
//   FIFO and control registers in one pass, and its result lands in the
//   output register, which drives out_valid_o and out_item_o.
//   Throughput is one item per cycle while the receiver does not stall,
//   set by the single decode/FIFO pass.
//   When the receiver stalls, the output register holds its result; the
//   pending input register holds, and in_stall_o rises only once both are
//   occupied. State is never updated for an item until its result can be
//   written, so no result is lost or repeated.
//   Reset empties the FIFO and clears the interrupt enable, loopback flag
//   and both pipeline valid bits; FIFO storage is not cleared and needs no
//   clearing pass.
module uart_register_block_rx_fifo #(
  parameter int unsigned FIFO_DEPTH = uartrx_pkg::FifoDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  uartrx_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output uartrx_pkg::out_item_t out_item_o
);

  logic                   in_valid_q;
  uartrx_pkg::in_item_t   in_item_q;
  logic                   out_valid_q;
  uartrx_pkg::out_item_t  out_item_q;
  uartrx_pkg::out_item_t  res;
  uartrx_pkg::fifo_req_t  req;
  uartrx_pkg::fifo_stat_t stat;
  logic                   advance;
  logic                   fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  uartrx_ctrl #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .stat_i (stat),
    .req_o  (req),
    .res_o  (res)
  );

  uartrx_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .stat_o (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for uart_register_block_rx_fifo: a clocked driver and monitor,
// an inline register/FIFO predictor, and random idling on both valid/stall channels.
// Depends on uartrx_pkg and the uart_register_block_rx_fifo RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned FifoDepth  = uartrx_pkg::FifoDepthDef;
  localparam logic [1:0]  CMD_NONE   = 2'd3;
  localparam int unsigned DirectedLen = 25;
  localparam int unsigned RandomLen  = 1750;
  localparam int unsigned MaxItems   = DirectedLen + RandomLen + 32;
  localparam int unsigned PressLo    = 560;
  localparam int unsigned PressHi    = 780;
  localparam int unsigned HoldAt     = 600;
  localparam int unsigned LongHold   = 150;
  localparam int unsigned TailCycles = 8;

  typedef struct {
    uartrx_pkg::in_item_t item;
    int unsigned          gap;
  } stim_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  uartrx_pkg::in_item_t  in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  uartrx_pkg::out_item_t out_item;

  stim_t                 pending_mem [MaxItems];
  uartrx_pkg::out_item_t exp_mem [MaxItems];
  int unsigned           pend_rd;
  int unsigned           exp_wr;
  int unsigned           exp_rd;

  int unsigned stim_total;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned rcv_cycle;
  int unsigned results_seen;
  logic        long_hold_done;
  int unsigned fail_cnt;

  // predictor state
  logic [7:0]       fifo_bytes [FifoDepth];
  int unsigned      fifo_head;
  uartrx_pkg::cnt_t fifo_level;
  logic [1:0]       ie_bits;
  logic             loop_on;

  int unsigned n_reads, n_writes, n_rx, n_refused, n_bus_err, n_loop_drop, peak_level;

  uart_register_block_rx_fifo #(
    .FIFO_DEPTH(FifoDepth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("Timeout at %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [31:0] lane_mask(input logic [3:0] n);
    if (n >= 4'd4) return '1;
    return (32'd1 << (8 * n)) - 32'd1;
  endfunction

  function automatic logic fifo_push(input logic [7:0] b);
    int unsigned tail;
    if (fifo_level >= FifoDepth) return 1'b0;
    tail = (fifo_head + fifo_level) % FifoDepth;
    fifo_bytes[tail] = b;
    fifo_level = fifo_level + 5'd1;
    if (fifo_level > peak_level) peak_level = fifo_level;
    return 1'b1;
  endfunction

  function automatic uartrx_pkg::out_item_t predict_uart(input uartrx_pkg::in_item_t it);
    uartrx_pkg::out_item_t r;
    logic [31:0]           lanes;
    logic [31:0]           wval;
    logic                  full;
    logic                  avail;
    r = '0;
    lanes = lane_mask(it.access_bytes);
    full = (fifo_level >= FifoDepth);
    avail = (fifo_level != 0);
    case (it.cmd)
      uartrx_pkg::CMD_READ: begin
        n_reads++;
        if (it.bus_offset > uartrx_pkg::OFF_CAP) begin
          r.bus_error = 1'b1;
          n_bus_err++;
        end else begin
          case (it.bus_offset)
            uartrx_pkg::OFF_DATA: begin
              if (avail) begin
                r.read_data = {24'd0, fifo_bytes[fifo_head]};
                fifo_head = (fifo_head + 1) % FifoDepth;
                fifo_level = fifo_level - 5'd1;
              end
            end
            uartrx_pkg::OFF_STATUS:
              r.read_data = {28'd0, full, avail, 1'b0, loop_on & full};
            uartrx_pkg::OFF_IE:     r.read_data = {30'd0, ie_bits};
            uartrx_pkg::OFF_IS:     r.read_data = {30'd0, 1'b1, avail};
            uartrx_pkg::OFF_LEVEL:  r.read_data = {27'd0, fifo_level};
            uartrx_pkg::OFF_CTRL:   r.read_data = {31'd0, loop_on};
            uartrx_pkg::OFF_CAP:
              r.read_data = {uartrx_pkg::CAP_VERSION, 8'(FifoDepth), 8'(FifoDepth)};
            default:                r.read_data = '0;
          endcase
          r.read_data = r.read_data & lanes;
        end
      end
      uartrx_pkg::CMD_WRITE: begin
        n_writes++;
        if (it.bus_offset > uartrx_pkg::OFF_CAP) begin
          r.bus_error = 1'b1;
          n_bus_err++;
        end else begin
          wval = it.write_data & lanes;
          case (it.bus_offset)
            uartrx_pkg::OFF_DATA: begin
              r.tx_valid = 1'b1;
              r.tx_byte = wval[7:0];
              if (loop_on) begin
                if (!fifo_push(wval[7:0])) n_loop_drop++;
              end
            end
            uartrx_pkg::OFF_IE:   ie_bits = wval[1:0];
            uartrx_pkg::OFF_CTRL: loop_on = wval[0];
            default: ;
          endcase
        end
      end
      uartrx_pkg::CMD_RX: begin
        n_rx++;
        r.rx_accepted = fifo_push(it.rx_byte);
        if (!r.rx_accepted) n_refused++;
      end
      default: ;
    endcase
    r.irq = ie_bits[0] && (fifo_level != 0);
    return r;
  endfunction

  function automatic int unsigned pick_send_gap(input int unsigned idx);
    int unsigned r;
    if ((idx >= PressLo && idx <= PressHi) || ((idx / 128) % 4 == 1)) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_stall(input int unsigned cyc);
    int unsigned r;
    if (cyc[9:8] == 2'b01) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_item(input logic [1:0] cmd, input logic [7:0] off, input logic [3:0] size,
                          input logic [31:0] wdata, input logic [7:0] rxb);
    stim_t s;
    s.item.cmd = cmd;
    s.item.bus_offset = off;
    s.item.access_bytes = size;
    s.item.write_data = wdata;
    s.item.rx_byte = rxb;
    s.gap = pick_send_gap(stim_total);
    pending_mem[stim_total] = s;
    stim_total++;
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      fail_cnt++;
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    stim_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pend_rd != stim_total) begin
        nxt = pending_mem[pend_rd];
        pend_rd = pend_rd + 1;
        in_item <= nxt.item;
        send_gap <= nxt.gap;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      rcv_cycle <= 0;
      long_hold_done <= 1'b0;
    end else begin
      rcv_cycle <= rcv_cycle + 1;
      if (!long_hold_done && results_seen >= HoldAt) begin
        long_hold_done <= 1'b1;
        stall_left <= LongHold - 1;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        stall_left <= pick_stall(rcv_cycle);
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: check results, then predict newly accepted items
  always @(posedge clk_i) begin
    uartrx_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (exp_rd == exp_wr) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, out_item);
          fail_cnt++;
        end else begin
          want = exp_mem[exp_rd];
          exp_rd = exp_rd + 1;
          check_field("read_data", want.read_data, out_item.read_data);
          check_field("bus_error", 32'(want.bus_error), 32'(out_item.bus_error));
          check_field("tx_valid", 32'(want.tx_valid), 32'(out_item.tx_valid));
          check_field("tx_byte", 32'(want.tx_byte), 32'(out_item.tx_byte));
          check_field("rx_accepted", 32'(want.rx_accepted), 32'(out_item.rx_accepted));
          check_field("irq", 32'(want.irq), 32'(out_item.irq));
        end
      end
      if (in_valid && !in_stall) begin
        exp_mem[exp_wr] = predict_uart(in_item);
        exp_wr = exp_wr + 1;
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned k;
    stim_total = 0;
    pend_rd = 0;
    exp_wr = 0;
    exp_rd = 0;
    results_seen = 0;
    fail_cnt = 0;
    fifo_head = 0;
    fifo_level = '0;
    ie_bits = '0;
    loop_on = 1'b0;
    n_reads = 0;
    n_writes = 0;
    n_rx = 0;
    n_refused = 0;
    n_bus_err = 0;
    n_loop_drop = 0;
    peak_level = 0;

    // directed
    add_item(uartrx_pkg::CMD_READ, uartrx_pkg::OFF_CAP, 4'd4, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_READ, uartrx_pkg::OFF_STATUS, 4'd8, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_READ, uartrx_pkg::OFF_IS, 4'd2, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_READ, uartrx_pkg::OFF_DATA, 4'd4, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_WRITE, uartrx_pkg::OFF_IE, 4'd1, 32'hFFFF_FFFF, 8'h0);
    add_item(uartrx_pkg::CMD_RX, 8'hFF, 4'd15, 32'hFFFF_FFFF, 8'hFF);
    add_item(uartrx_pkg::CMD_RX, 8'h00, 4'd0, 32'h0, 8'h00);
    add_item(uartrx_pkg::CMD_READ, uartrx_pkg::OFF_LEVEL, 4'd1, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_READ, uartrx_pkg::OFF_STATUS, 4'd4, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_READ, uartrx_pkg::OFF_DATA, 4'd0, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_READ, uartrx_pkg::OFF_DATA, 4'd8, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_WRITE, uartrx_pkg::OFF_CTRL, 4'd4, 32'h1, 8'h0);
    add_item(uartrx_pkg::CMD_WRITE, uartrx_pkg::OFF_DATA, 4'd1, 32'hFFFF_FFA5, 8'h0);
    add_item(uartrx_pkg::CMD_WRITE, uartrx_pkg::OFF_DATA, 4'd0, 32'hFFFF_FFFF, 8'h0);
    add_item(uartrx_pkg::CMD_READ, uartrx_pkg::OFF_CTRL, 4'd3, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_READ, 8'h03, 4'd4, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_WRITE, 8'h09, 4'd4, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_READ, uartrx_pkg::OFF_IE, 4'd4, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_READ, 8'h19, 4'd4, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_WRITE, 8'hFF, 4'd4, 32'hFFFF_FFFF, 8'h0);
    add_item(uartrx_pkg::CMD_WRITE, uartrx_pkg::OFF_CAP, 4'd4, 32'hFFFF_FFFF, 8'h0);
    add_item(uartrx_pkg::CMD_WRITE, uartrx_pkg::OFF_LEVEL, 4'd4, 32'h0, 8'h0);
    add_item(CMD_NONE, uartrx_pkg::OFF_DATA, 4'd4, 32'hFFFF_FFFF, 8'hFF);
    add_item(uartrx_pkg::CMD_WRITE, uartrx_pkg::OFF_IE, 4'd15, 32'h0, 8'h0);
    add_item(uartrx_pkg::CMD_READ, uartrx_pkg::OFF_DATA, 4'd15, 32'h0, 8'h0);

    // random sequences
    while (stim_total < DirectedLen + RandomLen) begin
      kind = $urandom_range(0, 99);
      if (kind < 22) begin
        k = $urandom_range(1, 20);
        repeat (k) add_item(uartrx_pkg::CMD_RX, 8'($urandom), 4'($urandom), $urandom,
                            8'($urandom));
      end else if (kind < 40) begin
        k = $urandom_range(1, 20);
        repeat (k) add_item(uartrx_pkg::CMD_READ, uartrx_pkg::OFF_DATA,
                            4'($urandom_range(1, 8)), $urandom, 8'($urandom));
      end else if (kind < 55) begin
        add_item(uartrx_pkg::CMD_READ, 8'(4 * $urandom_range(0, 6)), 4'($urandom), $urandom,
                 8'($urandom));
      end else if (kind < 68) begin
        add_item(uartrx_pkg::CMD_WRITE,
                 ($urandom_range(0, 1) != 0) ? uartrx_pkg::OFF_IE : uartrx_pkg::OFF_CTRL,
                 4'($urandom_range(0, 8)), $urandom, 8'($urandom));
      end else if (kind < 82) begin
        k = $urandom_range(1, 8);
        repeat (k) add_item(uartrx_pkg::CMD_WRITE, uartrx_pkg::OFF_DATA,
                            4'($urandom_range(0, 8)), $urandom, 8'($urandom));
      end else begin
        add_item(2'($urandom), 8'($urandom), 4'($urandom), $urandom, 8'($urandom));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend_rd != stim_total || in_valid || exp_rd != exp_wr) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Ran %0d items: %0d reads, %0d writes, %0d line bytes (%0d refused), %0d bus errs.",
             stim_total, n_reads, n_writes, n_rx, n_refused, n_bus_err);
    $display("FIFO peak %0d, %0d loopback bytes dropped on full, one %0d-cycle output hold.",
             peak_level, n_loop_drop, LongHold);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
